### design/radix_ascii_converter_core_defines.svh
// Assertion macros shared by the radix converter modules.
`ifndef RADIX_ASCII_CONVERTER_CORE_DEFINES_SVH
`define RADIX_ASCII_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and muted while rst_ni is low.
`define RAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and muted while rst_ni is low.
`define RAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rac_pkg.sv
// Shared constants, types and the digit character function of the radix converter.
`timescale 1ns / 1ps
package rac_pkg;

  // Field widths of the request and response items.
  localparam int unsigned ValueW    = 64;
  localparam int unsigned RadixW    = 5;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned CharW     = 8;
  localparam int unsigned InDataW   = 72;
  localparam int unsigned RadixLsb  = ValueW;
  localparam int unsigned UpperBit  = ValueW + RadixW;

  // Default sizes and the divider step.
  localparam int unsigned DefaultValueWidth = 64;
  localparam int unsigned DefaultMaxDigits  = 64;
  localparam int unsigned StepBits          = 8;

  // Accepted radix range.
  localparam logic [RadixW-1:0] RadixMin = 5'd2;
  localparam logic [RadixW-1:0] RadixMax = 5'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take a new number
    logic step;   // one divider step
    logic read;   // read the digit store at the readout pointer
    logic pop;    // move the readout pointer to the next lower digit
  } rac_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic radix_ok;    // radix of the incoming request is in range
    logic step_last;   // current step finishes a digit
    logic quot_zero;   // quotient after this step is zero
    logic store_full;  // the digit being finished fills the store
    logic last_char;   // readout pointer is at the least significant digit
  } rac_stat_t;

  // ASCII character of one digit value.
  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d,
                                                  input logic upper);
    logic [CharW-1:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'd0, d};
    end else if (upper) begin
      c = 8'h41 + {4'd0, d} - 8'd10;
    end else begin
      c = 8'h61 + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

### design/radix_ascii_converter_core.sv
// Top level of the radix converter: controller and datapath with stream ports.
//
//  Port group | Dir | tdata fields (low bit first)                     | tlast
//  s_axis     | in  | value[63:0], radix[68:64], upper_letters[69], 0s | -
//  m_axis     | out | digit_char[7:0]                                  | last_digit
//
// One request at a time; s_axis_tready_o is high only while the core is idle.
// Each digit takes ceil(VALUE_WIDTH/8) steps of the shared divider (8 for 64 bits),
// and each character is then read from the store and then output, which the receiver
// can stall. A radix outside 2..16 consumes the request with no output.
// Reset is asynchronous, active low; the digit store needs no clearing.
`timescale 1ns / 1ps
`include "radix_ascii_converter_core_defines.svh"
module radix_ascii_converter_core
  import rac_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = DefaultValueWidth,
  parameter int unsigned MAX_DIGITS  = DefaultMaxDigits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [InDataW-1:0] s_axis_tdata_i,   // value, radix, upper_letters, zero pad
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [CharW-1:0]   m_axis_tdata_o,   // digit_char
  output logic               m_axis_tlast_o
);

  rac_cmd_t  cmd;
  rac_stat_t stat;

  // Sequencing of division and readout.
  rac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Divider, digit store and character encoding.
  rac_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (s_axis_tdata_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .char_o    (m_axis_tdata_o)
  );

  assign m_axis_tlast_o = stat.last_char;

  `RAC_ASSERT_NEXT(a_busy_after_load, s_axis_tvalid_i && s_axis_tready_o && stat.radix_ok, !s_axis_tready_o && !m_axis_tvalid_o, "core not busy after a conversion request")
  `RAC_ASSERT_NEXT(a_idle_after_last, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o, s_axis_tready_o, "core not idle after the final character")

endmodule

### design/rac_ctrl.sv
// Controller state machine of the radix converter: division, then digit readout.
`timescale 1ns / 1ps
module rac_ctrl
  import rac_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  rac_stat_t stat_i,
  output rac_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_READ = 4'b0100,
    ST_SHOW = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // A request with a radix out of range is consumed without output.
        if (in_valid_i && stat_i.radix_ok) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (stat_i.step_last && (stat_i.quot_zero || stat_i.store_full)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (stat_i.last_char) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.pop = 1'b1;
            state_d   = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/rac_datapath.sv
// Datapath of the radix converter: shared divider, digit store and readout pointer.
`timescale 1ns / 1ps
`include "radix_ascii_converter_core_defines.svh"
module rac_datapath
  import rac_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = DefaultValueWidth,
  parameter int unsigned MAX_DIGITS  = DefaultMaxDigits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [InDataW-1:0] in_data_i,
  input  rac_cmd_t           cmd_i,
  output rac_stat_t          stat_o,
  output logic [CharW-1:0]   char_o
);

  localparam int unsigned NumSteps = (VALUE_WIDTH + StepBits - 1) / StepBits;
  localparam int unsigned QuotW    = NumSteps * StepBits;
  localparam int unsigned StepCntW = (NumSteps > 1) ? $clog2(NumSteps) : 1;
  localparam int unsigned AddrW    = $clog2(MAX_DIGITS);
  localparam int unsigned CountW   = $clog2(MAX_DIGITS + 1);

  logic [QuotW-1:0]    quot_q, quot_d;
  logic [DigitW-1:0]   rem_q, rem_d;
  logic [RadixW-1:0]   radix_q;
  logic                upper_q;
  logic [StepCntW-1:0] step_q;
  logic [CountW-1:0]   cnt_q;
  logic [AddrW-1:0]    ptr_q;
  logic [DigitW-1:0]   rd_q;
  logic [DigitW-1:0]   digit_mem_q [MAX_DIGITS];

  logic [RadixW-1:0]   in_radix;
  logic                step_last;

  assign in_radix  = in_data_i[RadixLsb +: RadixW];
  assign step_last = (step_q == StepCntW'(NumSteps - 1));

  // One divider step: StepBits quotient bits by restoring division.
  always_comb begin
    logic [RadixW-1:0]   r;
    logic [StepBits-1:0] top;
    logic [StepBits-1:0] qbits;
    r     = {1'b0, rem_q};
    top   = quot_q[QuotW-1 -: StepBits];
    qbits = '0;
    for (int i = StepBits - 1; i >= 0; i--) begin
      r = {r[DigitW-1:0], top[i]};
      if (r >= radix_q) begin
        r        = r - radix_q;
        qbits[i] = 1'b1;
      end
    end
    rem_d  = r[DigitW-1:0];
    quot_d = (quot_q << StepBits) | QuotW'(qbits);
  end

  // Status to the controller.
  always_comb begin
    stat_o.radix_ok   = (in_radix >= RadixMin) && (in_radix <= RadixMax);
    stat_o.step_last  = step_last;
    stat_o.quot_zero  = (quot_d == '0);
    stat_o.store_full = (cnt_q == CountW'(MAX_DIGITS - 1));
    stat_o.last_char  = (ptr_q == '0);
  end

  assign char_o = digit_char(rd_q, upper_q);

  // Quotient, remainder, step and digit counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= '0;
      rem_q  <= '0;
      step_q <= '0;
      cnt_q  <= '0;
      ptr_q  <= '0;
    end else if (cmd_i.load) begin
      quot_q <= QuotW'(in_data_i[VALUE_WIDTH-1:0]);
      rem_q  <= '0;
      step_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.step) begin
      quot_q <= quot_d;
      if (step_last) begin
        // The remainder becomes a digit; the next digit starts afresh.
        rem_q  <= '0;
        step_q <= '0;
        cnt_q  <= cnt_q + 1'b1;
        ptr_q  <= cnt_q[AddrW-1:0];
      end else begin
        rem_q  <= rem_d;
        step_q <= step_q + 1'b1;
      end
    end else if (cmd_i.pop) begin
      ptr_q <= ptr_q - 1'b1;
    end
  end

  // Request attributes held for the whole conversion.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      radix_q <= in_radix;
      upper_q <= in_data_i[UpperBit];
    end
  end

  // Digit store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && step_last) begin
      digit_mem_q[cnt_q[AddrW-1:0]] <= rem_d;
    end
    if (cmd_i.read) begin
      rd_q <= digit_mem_q[ptr_q];
    end
  end

  `RAC_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CountW'(MAX_DIGITS), "digit count beyond store")
  `RAC_ASSERT_NEXT(a_cnt_incr, cmd_i.step && step_last && !cmd_i.load, cnt_q == $past(cnt_q) + 1'b1, "digit count did not advance")

endmodule

### verif/tb_top.sv
// Self-checking testbench for the radix to ASCII converter core.
`timescale 1ns / 1ps
module tb_top;
  import rac_pkg::*;

  localparam int unsigned MaxDigits   = DefaultMaxDigits;
  localparam int unsigned DrainCycles = 1000;

  // One expected output character.
  typedef struct packed {
    logic [CharW-1:0] digit_char;
    logic             last_digit;
  } char_item_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;  // value, radix, upper_letters, zero pad
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [CharW-1:0]   m_axis_tdata;      // digit_char
  logic               m_axis_tlast;      // last_digit

  char_item_t expected_chars[$];
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_left = 0;
  int         error_count = 0;
  int         requests_sent = 0;
  int         requests_rejected = 0;
  int         chars_checked = 0;

  radix_ascii_converter_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Computes the characters of one number, most significant digit first.
  function automatic void predict_digits(input logic [ValueW-1:0] value,
                                         input logic [RadixW-1:0] radix,
                                         input logic upper);
    logic [DigitW-1:0] digits [MaxDigits];
    logic [ValueW-1:0] quot;
    int                n;
    string             charset;
    char_item_t        item;
    requests_sent++;
    // An out-of-range radix is swallowed without output.
    if (radix < RadixMin || radix > RadixMax) begin
      requests_rejected++;
      return;
    end
    charset = upper ? "0123456789ABCDEF" : "0123456789abcdef";
    quot = value;
    n = 0;
    if (quot == '0) begin
      digits[0] = '0;
      n = 1;
    end else begin
      // Extraction stops when the digit store is full.
      while (quot != '0 && n < MaxDigits) begin
        digits[n] = DigitW'(quot % radix);
        quot = quot / radix;
        n++;
      end
    end
    for (int k = n - 1; k >= 0; k--) begin
      item.digit_char = charset[digits[k]];
      item.last_digit = (k == 0);
      expected_chars.push_back(item);
    end
  endfunction

  // Offers one request, with random idle cycles first, and waits for its acceptance.
  task automatic send_number(input logic [ValueW-1:0] value,
                             input logic [RadixW-1:0] radix,
                             input logic upper);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {2'b00, upper, radix, value};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_digits(value, radix, upper);
  endtask

  // Lowers the request valid and waits until every expected character came out.
  task automatic wait_drained(input int extra_cycles);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (extra_cycles) @(posedge clk_i);
  endtask

  // Receiver side: a long hold-off when requested, else random stalls.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compares every accepted character with the oldest expectation.
  always @(posedge clk_i) begin
    char_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: digit_char %h last_digit %b",
               m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (m_axis_tdata !== want.digit_char) begin
          $error("digit_char mismatch: expected %h, actual %h", want.digit_char, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tlast !== want.last_digit) begin
          $error("last_digit mismatch: expected %b, actual %b", want.last_digit, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  // Zero, all-ones values and radices outside the accepted range.
  task automatic test_edge_values();
    send_number('0, 5'd10, 1'b0);
    send_number('0, 5'd16, 1'b1);
    send_number('1, 5'd2, 1'b0);
    send_number('1, 5'd16, 1'b0);
    send_number('1, 5'd16, 1'b1);
    send_number(64'd12345, 5'd0, 1'b0);
    send_number(64'd12345, 5'd1, 1'b1);
    send_number(64'd12345, 5'd17, 1'b0);
    send_number(64'd12345, 5'd31, 1'b1);
    wait_drained(20);
  endtask

  // Every accepted radix, with the letter case alternating from radix to radix.
  task automatic test_radix_sweep();
    for (int r = RadixMin; r <= RadixMax; r++) begin
      send_number(64'hFEDC_BA98_7654_3210, RadixW'(r), r[0]);
    end
    wait_drained(20);
  endtask

  // Random numbers, mostly short, with a few bad radices mixed in.
  task automatic test_random_numbers(input int count, input int idle_pct, input int stall_pct);
    logic [ValueW-1:0] value;
    logic [RadixW-1:0] radix;
    int                bits;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      bits  = ($urandom_range(9) < 8) ? $urandom_range(20, 1) : $urandom_range(64, 21);
      value = {$urandom, $urandom};
      if (bits < 64) value = value & ((64'd1 << bits) - 64'd1);
      value[bits-1] = 1'b1;
      if ($urandom_range(29) == 0) value = '0;
      if ($urandom_range(19) == 0) begin
        radix = $urandom_range(1) ? RadixW'($urandom_range(1, 0)) : RadixW'($urandom_range(31, 17));
      end else begin
        radix = RadixW'($urandom_range(16, 2));
      end
      send_number(value, radix, 1'($urandom_range(1)));
    end
    wait_drained(20);
  endtask

  // The receiver holds off for a long time while requests keep coming.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    hold_left = 3000;
    repeat (6) begin
      send_number({$urandom, $urandom}, RadixW'($urandom_range(16, 2)), 1'($urandom_range(1)));
    end
    wait_drained(20);
  endtask

  // Test sequence.
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_edge_values();
    test_radix_sweep();
    test_random_numbers(105, 0, 0);
    test_random_numbers(105, 51, 0);
    test_random_numbers(105, 0, 51);
    test_random_numbers(105, 29, 29);
    test_output_backpressure();
    wait_drained(DrainCycles);
    if (expected_chars.size() != 0) begin
      $error("%0d expected characters never arrived", expected_chars.size());
      error_count++;
    end
    $display("Covered %0d numbers (%0d with a bad radix) and %0d characters,",
             requests_sent, requests_rejected, chars_checked);
    $display("under idle sender, stalled receiver and a long output hold-off.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

### radix_ascii_converter_core.f
+incdir+design
design/rac_pkg.sv
design/rac_ctrl.sv
design/rac_datapath.sv
design/radix_ascii_converter_core.sv
verif/tb_top.sv
